[sv/tls_hello_parser_core_defines.svh]
// ----------------------------------------------------------------------------
// TLS hello parser assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef TLS_HELLO_PARSER_CORE_DEFINES_SVH
`define TLS_HELLO_PARSER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define THP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hello parser assertion failed");
`define THP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hello parser implication failed");
`else
`define THP_ASSERT(lbl, prop)
`define THP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[sv/thp_pkg.sv]
// ----------------------------------------------------------------------------
// TLS hello parser package
// Field kinds, parse phases and the decoded field record.
// ----------------------------------------------------------------------------
package thp_pkg;

    localparam int unsigned RANDOM_LEN       = 28;
    localparam int unsigned SERVER_SUITE_LEN = 'h0002;

    localparam logic [2:0] KIND_VERSION   = 3'd0;
    localparam logic [2:0] KIND_TIME      = 3'd1;
    localparam logic [2:0] KIND_RANDOM    = 3'd2;
    localparam logic [2:0] KIND_SESS_LEN  = 3'd3;
    localparam logic [2:0] KIND_SESS_BYTE = 3'd4;
    localparam logic [2:0] KIND_SUITE_LEN = 3'd5;
    localparam logic [2:0] KIND_SUITE_ID  = 3'd6;
    localparam logic [2:0] KIND_COMP      = 3'd7;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_VERSION   = 10'b00_0000_0010,
        PH_TIME      = 10'b00_0000_0100,
        PH_RANDOM    = 10'b00_0000_1000,
        PH_SESSLEN   = 10'b00_0001_0000,
        PH_SESSBYTES = 10'b00_0010_0000,
        PH_CIPHER    = 10'b00_0100_0000,
        PH_SUITES    = 10'b00_1000_0000,
        PH_COMP      = 10'b01_0000_0000,
        PH_METHODS   = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [14:0] index;
        logic        is_count;
        logic        done;
    } t_field;

endpackage

[sv/thp_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register
// Captures one message byte and its start flag per transfer.
// ----------------------------------------------------------------------------
module thp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_start
);
    import thp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_byte;
            r_start <= i_start;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;
endmodule

[sv/thp_decoder.sv]
// ----------------------------------------------------------------------------
// Hello field decoder
// Parse phase, byte counter, accumulator and repeat counters, one byte a cycle while i_fire is high.
// ----------------------------------------------------------------------------
module thp_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    input  logic            i_server,
    output logic            o_emit,
    output thp_pkg::t_field o_field
);
    import thp_pkg::*;

    t_phase      r_phase, n_phase, b_phase;
    logic [2:0]  r_bif, n_bif, b_bif, bif_inc;
    logic [31:0] r_acc, n_acc, b_acc, acc_sh;
    logic [14:0] r_rem, n_rem, b_rem, rem_dec;
    logic [14:0] r_idx, n_idx, b_idx, idx_inc;
    logic        emit;
    t_field      fld;

    always_comb begin
        b_phase = r_phase;
        b_bif   = r_bif;
        b_acc   = r_acc;
        b_rem   = r_rem;
        b_idx   = r_idx;
        if (i_start) begin
            b_phase = PH_VERSION;
            b_bif   = '0;
            b_acc   = '0;
            b_rem   = '0;
            b_idx   = '0;
        end
        acc_sh  = {b_acc[23:0], i_byte};
        bif_inc = b_bif + 3'd1;
        idx_inc = b_idx + 15'd1;
        rem_dec = b_rem - 15'd1;

        n_phase = b_phase;
        n_bif   = bif_inc;
        n_acc   = acc_sh;
        n_rem   = b_rem;
        n_idx   = b_idx;
        emit    = 1'b0;
        fld     = '0;

        unique case (b_phase)
            PH_IDLE: begin
                // No start flag: the byte is dropped and nothing moves.
                n_bif = b_bif;
                n_acc = b_acc;
            end
            PH_VERSION: begin
                if (bif_inc >= 3'd2) begin
                    emit      = 1'b1;
                    fld.kind  = KIND_VERSION;
                    fld.value = {16'd0, acc_sh[15:0]};
                    n_phase   = PH_TIME;
                end
            end
            PH_TIME: begin
                if (bif_inc >= 3'd4) begin
                    emit      = 1'b1;
                    fld.kind  = KIND_TIME;
                    fld.value = acc_sh;
                    n_idx     = '0;
                    n_phase   = PH_RANDOM;
                end
            end
            PH_RANDOM: begin
                emit      = 1'b1;
                fld.kind  = KIND_RANDOM;
                fld.value = {24'd0, i_byte};
                fld.index = b_idx;
                n_idx     = idx_inc;
                if (idx_inc >= 15'(RANDOM_LEN)) begin
                    n_idx   = '0;
                    n_phase = PH_SESSLEN;
                end
            end
            PH_SESSLEN: begin
                emit      = 1'b1;
                fld.kind  = KIND_SESS_LEN;
                fld.value = {24'd0, i_byte};
                n_rem     = {7'd0, i_byte};
                n_idx     = '0;
                n_phase   = (i_byte != 8'd0) ? PH_SESSBYTES : PH_CIPHER;
            end
            PH_SESSBYTES: begin
                emit      = 1'b1;
                fld.kind  = KIND_SESS_BYTE;
                fld.value = {24'd0, i_byte};
                fld.index = b_idx;
                n_idx     = idx_inc;
                n_rem     = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_CIPHER;
                end
            end
            PH_CIPHER: begin
                if (bif_inc >= 3'd2) begin
                    emit      = 1'b1;
                    fld.value = {16'd0, acc_sh[15:0]};
                    if (i_server) begin
                        fld.kind = KIND_SUITE_ID;
                        n_rem    = 15'(SERVER_SUITE_LEN >> 1);
                        n_phase  = PH_COMP;
                    end else begin
                        // Suite count is length/2; an odd length rounds down.
                        fld.kind = KIND_SUITE_LEN;
                        n_rem    = acc_sh[15:1];
                        n_idx    = '0;
                        n_phase  = (acc_sh[15:1] != '0) ? PH_SUITES : PH_COMP;
                    end
                end
            end
            PH_SUITES: begin
                if (bif_inc >= 3'd2) begin
                    emit      = 1'b1;
                    fld.kind  = KIND_SUITE_ID;
                    fld.value = {16'd0, acc_sh[15:0]};
                    fld.index = b_idx;
                    n_idx     = idx_inc;
                    n_rem     = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_COMP;
                    end
                end
            end
            PH_COMP: begin
                emit      = 1'b1;
                fld.kind  = KIND_COMP;
                fld.value = {24'd0, i_byte};
                n_idx     = '0;
                if (i_server) begin
                    fld.done = 1'b1;
                    n_phase  = PH_IDLE;
                end else begin
                    fld.is_count = 1'b1;
                    n_rem        = {7'd0, i_byte};
                    if (i_byte == 8'd0) begin
                        fld.done = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_phase = PH_METHODS;
                    end
                end
            end
            PH_METHODS: begin
                emit      = 1'b1;
                fld.kind  = KIND_COMP;
                fld.value = {24'd0, i_byte};
                fld.index = b_idx;
                n_idx     = idx_inc;
                n_rem     = rem_dec;
                if (rem_dec == '0) begin
                    fld.done = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_bif   = '0;
                n_acc   = '0;
            end
        endcase

        if (emit) begin
            n_bif = '0;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bif   <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_idx   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_idx   <= n_idx;
        end
    end

    assign o_emit  = i_fire && emit;
    assign o_field = fld;
endmodule

[sv/thp_out_stage.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded field until the receiver takes it.
// ----------------------------------------------------------------------------
module thp_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  thp_pkg::t_field i_field,
    input  logic            i_ready,
    output logic            o_valid,
    output logic            o_free,
    output thp_pkg::t_field o_field
);
    import thp_pkg::*;

    logic   r_valid;
    t_field r_field;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_field <= i_field;
        end
    end

    assign o_valid = r_valid;
    assign o_field = r_field;
endmodule

[sv/tls_hello_parser_core.sv]
// Hello message parser for the client and server hello bodies.
// Input channel: one body byte per transfer (i_msg_byte), with i_msg_start
// high on the first byte of a message; that byte restarts any parse in flight.
// Output channel: one decoded field per transfer: kind, big-endian value,
// position within a repeated field, the compression count flag and a flag on
// the last field of the message. Bytes that only complete part of a field,
// and bytes outside a message, produce no transfer.
// Configuration: a write of i_cfg_data selects the server layout (1) or the
// client layout (0); write it between messages.
// An accepted byte is held in the input register, then decoded into the
// result register, which drives the output channel.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its field and the
// input register holds the next byte; input ready drops only when both are
// full. Reset clears both registers, the layout select and the parse state,
// leaving the parser idle until a start byte.
`include "tls_hello_parser_core_defines.svh"
// ----------------------------------------------------------------------------
// TLS hello parser top level
// Input register, field decoder and result register with handshakes.
// ----------------------------------------------------------------------------
module tls_hello_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_msg_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_field_kind,
    output logic [31:0] o_field_value,
    output logic [14:0] o_item_index,
    output logic        o_is_count,
    output logic        o_message_done
);
    import thp_pkg::*;

    logic       r_is_server;
    logic       s1_valid, s1_start, out_free, dec_fire, dec_emit;
    logic [7:0] s1_byte;
    t_field     dec_field, out_field;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_server <= 1'b0;
        end else if (i_cfg_valid) begin
            r_is_server <= i_cfg_data;
        end
    end

    thp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_msg_byte),
        .i_start (i_msg_start),
        .i_take  (out_free),
        .o_valid (s1_valid),
        .o_byte  (s1_byte),
        .o_start (s1_start)
    );

    // A byte leaves the input register whenever the result register can
    // take a field, whether or not the byte completes one.
    assign dec_fire = s1_valid && out_free;

    thp_decoder u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (dec_fire),
        .i_byte   (s1_byte),
        .i_start  (s1_start),
        .i_server (r_is_server),
        .o_emit   (dec_emit),
        .o_field  (dec_field)
    );

    thp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dec_emit),
        .i_field (dec_field),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_field (out_field)
    );

    assign o_field_kind   = out_field.kind;
    assign o_field_value  = out_field.value;
    assign o_item_index   = out_field.index;
    assign o_is_count     = out_field.is_count;
    assign o_message_done = out_field.done;

    `THP_ASSERT_IMP(a_done_is_comp, o_out_valid && o_message_done,
                    o_field_kind == KIND_COMP)
    `THP_ASSERT_IMP(a_count_is_comp, o_out_valid && o_is_count,
                    o_field_kind == KIND_COMP && o_item_index == '0)
    `THP_ASSERT_IMP(a_index_kind, o_out_valid && o_item_index != '0,
                    o_field_kind == KIND_RANDOM || o_field_kind == KIND_SESS_BYTE ||
                    o_field_kind == KIND_SUITE_ID || o_field_kind == KIND_COMP)
    `THP_ASSERT(a_stall_blocks_input,
                (s1_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLS hello parser testbench
// Feeds client and server hello bodies, some of them cut short or followed by
// stray bytes, through the byte channel under random stalls on both sides.
// The expected fields are decoded alongside and compared with the output.
// ----------------------------------------------------------------------------
module tb;
    import thp_pkg::*;

    localparam int WHOLE       = 1 << 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_wire_byte;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  msg_byte = 8'h00;
    logic        msg_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  field_kind;
    logic [31:0] field_value;
    logic [14:0] item_index;
    logic        is_count;
    logic        message_done;

    t_wire_byte  bytes_to_send[$];
    t_field      fields_due[$];
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          idle_pct = 31;
    int          cycle_count = 0;
    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;

    // Decoder state kept alongside the block.
    logic        server_layout = 1'b0;
    t_phase      parse_ph = PH_IDLE;
    logic [4:0]  field_bytes = '0;
    logic [31:0] accum = '0;
    logic [15:0] bytes_left = '0;
    logic [14:0] rep_idx = '0;

    tls_hello_parser_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_msg_byte     (msg_byte),
        .i_msg_start    (msg_start),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_field_kind   (field_kind),
        .o_field_value  (field_value),
        .o_item_index   (item_index),
        .o_is_count     (is_count),
        .o_message_done (message_done)
    );

    always #2 clk = ~clk;

    function automatic t_field close_field(input logic [2:0] kind, input logic [31:0] value,
                                           input logic [14:0] pos, input logic cnt,
                                           input logic last);
        t_field f;
        f = '{kind: kind, value: value, index: pos, is_count: cnt, done: last};
        field_bytes = '0;
        accum = '0;
        return f;
    endfunction

    // Advances the decoder by one byte; returns 1 when a field completes.
    function automatic bit decode_hello_byte(input logic [7:0] b, input logic first,
                                             output t_field f);
        logic [14:0] pos;
        f = '0;
        if (first) begin
            parse_ph = PH_VERSION;
            field_bytes = '0;
            accum = '0;
            bytes_left = '0;
            rep_idx = '0;
        end else if (parse_ph == PH_IDLE) begin
            return 1'b0;
        end
        accum = {accum[23:0], b};
        field_bytes = field_bytes + 5'd1;
        case (parse_ph)
            PH_VERSION: begin
                if (field_bytes < 5'd2) return 1'b0;
                parse_ph = PH_TIME;
                f = close_field(KIND_VERSION, {16'h0, accum[15:0]}, '0, 1'b0, 1'b0);
            end
            PH_TIME: begin
                if (field_bytes < 5'd4) return 1'b0;
                parse_ph = PH_RANDOM;
                rep_idx = '0;
                f = close_field(KIND_TIME, accum, '0, 1'b0, 1'b0);
            end
            PH_RANDOM: begin
                pos = rep_idx;
                rep_idx = rep_idx + 15'd1;
                if (rep_idx >= RANDOM_LEN) begin
                    rep_idx = '0;
                    parse_ph = PH_SESSLEN;
                end
                f = close_field(KIND_RANDOM, {24'h0, b}, pos, 1'b0, 1'b0);
            end
            PH_SESSLEN: begin
                bytes_left = {8'h0, b};
                rep_idx = '0;
                parse_ph = (b != 8'd0) ? PH_SESSBYTES : PH_CIPHER;
                f = close_field(KIND_SESS_LEN, {24'h0, b}, '0, 1'b0, 1'b0);
            end
            PH_SESSBYTES: begin
                pos = rep_idx;
                rep_idx = rep_idx + 15'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) parse_ph = PH_CIPHER;
                f = close_field(KIND_SESS_BYTE, {24'h0, b}, pos, 1'b0, 1'b0);
            end
            PH_CIPHER: begin
                if (field_bytes < 5'd2) return 1'b0;
                if (server_layout) begin
                    bytes_left = 16'(SERVER_SUITE_LEN >> 1);
                    parse_ph = PH_COMP;
                    f = close_field(KIND_SUITE_ID, {16'h0, accum[15:0]}, '0, 1'b0, 1'b0);
                end else begin
                    bytes_left = {1'b0, accum[15:1]};
                    rep_idx = '0;
                    parse_ph = (bytes_left != 16'd0) ? PH_SUITES : PH_COMP;
                    f = close_field(KIND_SUITE_LEN, {16'h0, accum[15:0]}, '0, 1'b0, 1'b0);
                end
            end
            PH_SUITES: begin
                if (field_bytes < 5'd2) return 1'b0;
                pos = rep_idx;
                rep_idx = rep_idx + 15'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) parse_ph = PH_COMP;
                f = close_field(KIND_SUITE_ID, {16'h0, accum[15:0]}, pos, 1'b0, 1'b0);
            end
            PH_COMP: begin
                rep_idx = '0;
                if (server_layout) begin
                    parse_ph = PH_IDLE;
                    f = close_field(KIND_COMP, {24'h0, b}, '0, 1'b0, 1'b1);
                end else begin
                    bytes_left = {8'h0, b};
                    if (b == 8'd0) begin
                        parse_ph = PH_IDLE;
                        f = close_field(KIND_COMP, '0, '0, 1'b1, 1'b1);
                    end else begin
                        parse_ph = PH_METHODS;
                        f = close_field(KIND_COMP, {24'h0, b}, '0, 1'b1, 1'b0);
                    end
                end
            end
            PH_METHODS: begin
                pos = rep_idx;
                rep_idx = rep_idx + 15'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) parse_ph = PH_IDLE;
                f = close_field(KIND_COMP, {24'h0, b}, pos, 1'b0, bytes_left == 16'd0);
            end
            default: begin
                parse_ph = PH_IDLE;
                field_bytes = '0;
                accum = '0;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic [7:0] body_byte(input int fill);
        return (fill < 0) ? 8'($urandom) : 8'(fill);
    endfunction

    // Builds one hello body and queues its first keep bytes.
    task automatic add_hello(input bit server, input int sess_len, input int suite_len,
                             input int comp_cnt, input int keep, input int fill);
        logic [7:0] msg[$];
        for (int i = 0; i < 6 + RANDOM_LEN; i++) msg.push_back(body_byte(fill));
        msg.push_back(8'(sess_len));
        for (int i = 0; i < sess_len; i++) msg.push_back(body_byte(fill));
        if (server) begin
            for (int i = 0; i < 3; i++) msg.push_back(body_byte(fill));
        end else begin
            msg.push_back(8'(suite_len >> 8));
            msg.push_back(8'(suite_len));
            for (int i = 0; i < (suite_len / 2) * 2 && msg.size() < keep; i++) begin
                msg.push_back(body_byte(fill));
            end
            msg.push_back(8'(comp_cnt));
            for (int i = 0; i < comp_cnt; i++) msg.push_back(body_byte(fill));
        end
        for (int i = 0; i < msg.size() && i < keep; i++) begin
            bytes_to_send.push_back('{data: msg[i], start: (i == 0)});
            bytes_queued++;
        end
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) begin
            bytes_to_send.push_back('{data: 8'($urandom), start: 1'b0});
            bytes_queued++;
        end
    endtask

    // Returns at a falling edge once every byte is taken and every field seen.
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || fields_due.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_layout(input logic server);
        cfg_valid <= 1'b1;
        cfg_data <= server;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Byte sender: a new transfer is offered only after the previous one is taken.
    always @(negedge clk) begin : sender
        t_wire_byte item;
        if (rst_n && (!in_valid || in_taken)) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
                item = bytes_to_send.pop_front();
                in_valid <= 1'b1;
                msg_byte <= item.data;
                msg_start <= item.start;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin : monitor
        t_field decoded;
        t_field seen;
        t_field want;
        in_taken <= rst_n && in_valid && in_ready;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) server_layout = cfg_data;
            if (in_valid && in_ready) begin
                bytes_taken++;
                if (decode_hello_byte(msg_byte, msg_start, decoded)) begin
                    fields_due.push_back(decoded);
                end
            end
            if (out_valid && out_ready) begin
                seen = '{kind: field_kind, value: field_value, index: item_index,
                         is_count: is_count, done: message_done};
                if (fields_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected field: kind %0d value %h index %0d cnt %b done %b",
                                 seen.kind, seen.value, seen.index, seen.is_count, seen.done);
                    end
                end else begin
                    want = fields_due.pop_front();
                    if (seen != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("field mismatch: expected kind %0d value %h index %0d cnt %b done %b",
                                     want.kind, want.value, want.index, want.is_count, want.done);
                            $display("                actual   kind %0d value %h index %0d cnt %b done %b",
                                     seen.kind, seen.value, seen.index, seen.is_count, seen.done);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        int sess_len;
        int suite_len;
        int comp_cnt;
        int keep;
        int phase_from;
        int n_phase;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Client layout: stray bytes while idle, a restart mid-message, an empty
        // session with no suites and no methods, then an odd suite length.
        write_layout(1'b0);
        @(posedge clk);
        add_noise(2);
        add_hello(1'b0, 0, 0, 0, 4, -1);
        add_hello(1'b0, 0, 0, 0, WHOLE, 8'hFF);
        add_hello(1'b0, 1, 3, 1, WHOLE, 8'h00);
        add_noise(3);
        wait_drained();

        // Server layout: one cipher id and a single compression byte.
        write_layout(1'b1);
        @(posedge clk);
        add_hello(1'b1, 32, 0, 0, WHOLE, -1);
        add_hello(1'b1, 0, 0, 0, WHOLE, 8'hFF);
        wait_drained();

        n_phase = 0;
        while (bytes_queued < 1300) begin
            write_layout(n_phase[0]);
            @(posedge clk);
            // One phase runs without any idling on either side.
            idle_pct = (n_phase == 2) ? 0 : 31;
            phase_from = bytes_queued;
            while (bytes_queued - phase_from < 180) begin
                r = $urandom_range(99);
                sess_len = (r < 70) ? $urandom_range(8) : (r < 96) ? $urandom_range(32, 9) : 255;
                r = $urandom_range(99);
                suite_len = (r < 55) ? $urandom_range(12) :
                            (r < 80) ? $urandom_range(64, 13) :
                            (r < 90) ? 2 * $urandom_range(6) + 1 :
                                       $urandom_range(16'hFFFF, 16'h8000);
                r = $urandom_range(99);
                comp_cnt = (r < 60) ? $urandom_range(3) : (r < 96) ? $urandom_range(20, 4) : 255;
                // A huge suite list is always cut short.
                if (suite_len >= 16'h8000) keep = $urandom_range(120, 40);
                else if ($urandom_range(99) < 15) keep = $urandom_range(60, 1);
                else keep = WHOLE;
                add_hello(n_phase[0], sess_len, suite_len, comp_cnt, keep, -1);
                if ($urandom_range(99) < 25) add_noise($urandom_range(4, 1));
            end
            wait_drained();
            n_phase++;
        end

        if (mismatches == 0 && fields_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/thp_pkg.sv
sv/thp_in_stage.sv
sv/thp_decoder.sv
sv/thp_out_stage.sv
sv/tls_hello_parser_core.sv
tb/tb.sv
